@@ hdl/unit_hydrograph_sediment_routing_defines.svh @@
// Assertion macros for the sediment routing block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef UNIT_HYDROGRAPH_SEDIMENT_ROUTING_DEFINES_SVH
`define UNIT_HYDROGRAPH_SEDIMENT_ROUTING_DEFINES_SVH

// same-cycle implication, off during reset
`define UHSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define UHSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/uhsr_pkg.sv @@
// Types, codes and helpers shared by the sediment routing block.
// No dependencies.
package uhsr_pkg;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_EOS  = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [1:0] KIND_OUTFLOW = 2'd0;
  localparam logic [1:0] KIND_SUM     = 2'd1;
  localparam logic [1:0] KIND_TOTAL   = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  cell_index;
    logic [3:0]  delay_position;
    logic [15:0] weight;
    logic [31:0] sediment_yield;
    logic [3:0]  subbasin_id;
  } uhsr_in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  index;
    logic [31:0] amount;
    logic        last;
  } uhsr_out_word_t;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic mac_issue;
    logic sum_rd;
    logic sum_upd;
    logic err_emit;
    logic eos_rd;
    logic eos_emit;
    logic total_emit;
  } uhsr_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] act;
    logic       cell_bad;
    logic       cnt_zero;
    logic       mac_last;
    logic       pipe_empty;
    logic       target_bad;
    logic       sweep_last;
    logic       out_free;
  } uhsr_sts_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ hdl/uhsr_ctrl.sv @@
// Sequencer of the sediment routing block: clear sweep, MAC pass, sum update, end-of-step sweep.
// Depends on uhsr_pkg.
module uhsr_ctrl import uhsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  uhsr_sts_t sts,
  output uhsr_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_MAC    = 10'b00_0000_0100,
    S_DRAIN  = 10'b00_0000_1000,
    S_SUMRD  = 10'b00_0001_0000,
    S_SUMUPD = 10'b00_0010_0000,
    S_ERR    = 10'b00_0100_0000,
    S_EOSRD  = 10'b00_1000_0000,
    S_EOSOUT = 10'b01_0000_0000,
    S_TOTAL  = 10'b10_0000_0000
  } uhsr_state_t;

  uhsr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (sts.act)
            ACT_STEP: state_nxt = sts.cell_bad ? S_ERR : S_MAC;
            ACT_EOS:  state_nxt = sts.cnt_zero ? S_TOTAL : S_EOSRD;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (sts.mac_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts.pipe_empty) state_nxt = sts.target_bad ? S_ERR : S_SUMRD;
      end
      S_SUMRD: begin
        cmd.sum_rd = 1'b1;
        state_nxt  = S_SUMUPD;
      end
      S_SUMUPD: begin
        if (sts.out_free) begin
          cmd.sum_upd = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.err_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EOSRD: begin
        cmd.eos_rd = 1'b1;
        state_nxt  = S_EOSOUT;
      end
      S_EOSOUT: begin
        if (sts.out_free) begin
          cmd.eos_emit = 1'b1;
          state_nxt    = sts.sweep_last ? S_TOTAL : S_EOSRD;
        end
      end
      S_TOTAL: begin
        if (sts.out_free) begin
          cmd.total_emit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

@@ hdl/uhsr_datapath.sv @@
// Datapath of the sediment routing block: delay and weight memories, MAC pipe,
// subbasin sum memory, config register and output register. Depends on uhsr_pkg.
module uhsr_datapath import uhsr_pkg::*; #(
  parameter int CELLS     = 1024,
  parameter int DELAYS    = 16,
  parameter int SUBBASINS = 15
) (
  input  logic           clk,
  input  logic           rst_n,
  input  uhsr_in_word_t  in_data,
  input  logic           cfg_we,
  input  logic [3:0]     cfg_data,
  input  uhsr_cmd_t      cmd,
  output uhsr_sts_t      sts,
  output logic           out_valid,
  input  logic           out_ready,
  output uhsr_out_word_t out_data
);

  localparam int DEPTH = CELLS * DELAYS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int JW    = (DELAYS > 1) ? $clog2(DELAYS) : 1;
  localparam int SN    = SUBBASINS + 1;
  localparam int SW    = $clog2(SN);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
  localparam logic [JW-1:0] J_LAST   = JW'(DELAYS - 1);

  logic [31:0] delay_mem  [DEPTH];
  logic [15:0] weight_mem [DEPTH];
  logic [31:0] sum_mem    [SN];

  logic [3:0]     cnt_r;
  uhsr_in_word_t  item_r;
  logic [AW-1:0]  base_r;
  logic [AW-1:0]  clr_r;
  logic [JW-1:0]  j_r;
  logic           v1_r, v2_r;
  logic           last1_r, first1_r, first2_r;
  logic [AW-1:0]  wa1_r, wa2_r;
  logic [15:0]    rd_w_r;
  logic [31:0]    rd_d_r;
  logic [47:0]    prod_r;
  logic [31:0]    sh_r;
  logic [31:0]    outflow_r;
  logic [31:0]    sum_rd_r;
  logic           sum_rd_vld_r;
  logic [SN-1:0]  sum_vld_r;
  logic [3:0]     i_r;
  logic [31:0]    total_r;
  logic           out_valid_r;
  uhsr_out_word_t out_r;

  logic [3:0]    eff_cnt;
  logic [3:0]    target;
  logic          target_bad;
  logic          in_cell_bad;
  logic          load_we;
  logic [AW-1:0] load_addr;
  logic          j_last;
  logic [AW-1:0] rd_w_addr, rd_d_addr;
  logic [31:0]   mac_sum;
  logic [31:0]   sum_val;
  logic [SW-1:0] sum_ra, sum_wa;
  logic          out_load;

  assign eff_cnt     = (int'(cnt_r) > SUBBASINS) ? 4'(SUBBASINS) : cnt_r;
  assign target      = (cnt_r == 4'd1) ? 4'd1 : item_r.subbasin_id;
  assign target_bad  = (target == 4'd0) || (target > eff_cnt);
  assign in_cell_bad = int'(in_data.cell_index) >= CELLS;
  assign load_we     = cmd.accept && (in_data.action == ACT_LOAD) && !in_cell_bad
                       && (int'(in_data.delay_position) < DELAYS);
  assign load_addr   = AW'(int'(in_data.cell_index) * DELAYS + int'(in_data.delay_position));
  assign j_last      = (j_r == J_LAST);
  assign rd_w_addr   = base_r + AW'(j_r);
  assign rd_d_addr   = j_last ? base_r : base_r + AW'(j_r) + 1'b1;
  assign mac_sum     = (item_r.sediment_yield != 32'd0) ? sat_add(sh_r, prod_r[47:16]) : sh_r;
  assign sum_val     = sum_rd_vld_r ? sum_rd_r : 32'd0;
  assign sum_ra      = cmd.eos_rd ? SW'(i_r) : SW'(target);
  assign sum_wa      = SW'(target);
  assign out_load    = cmd.sum_upd || cmd.err_emit || cmd.eos_emit || cmd.total_emit;

  always_comb begin
    sts.clr_last   = (clr_r == CLR_LAST);
    sts.act        = in_data.action;
    sts.cell_bad   = in_cell_bad;
    sts.cnt_zero   = (eff_cnt == 4'd0);
    sts.mac_last   = j_last;
    sts.pipe_empty = !v1_r && !v2_r;
    sts.target_bad = target_bad;
    sts.sweep_last = (i_r == eff_cnt);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // delay and weight memories
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      delay_mem[clr_r]  <= 32'd0;
      weight_mem[clr_r] <= 16'd0;
    end else begin
      if (v2_r) delay_mem[wa2_r] <= mac_sum;
      if (load_we) weight_mem[load_addr] <= in_data.weight;
    end
    if (cmd.mac_issue) begin
      rd_w_r <= weight_mem[rd_w_addr];
      rd_d_r <= delay_mem[rd_d_addr];
    end
  end

  // subbasin sum memory
  always_ff @(posedge clk) begin
    if (cmd.sum_upd) sum_mem[sum_wa] <= sat_add(sum_val, outflow_r);
    if (cmd.sum_rd || cmd.eos_rd) sum_rd_r <= sum_mem[sum_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r    <= '0;
      sum_rd_vld_r <= 1'b0;
    end else begin
      if (cmd.total_emit) begin
        sum_vld_r <= '0;
      end else if (cmd.sum_upd) begin
        sum_vld_r[sum_wa] <= 1'b1;
      end
      if (cmd.sum_rd || cmd.eos_rd) sum_rd_vld_r <= sum_vld_r[sum_ra];
    end
  end

  // control counters and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 4'd1;
      clr_r       <= '0;
      j_r         <= '0;
      i_r         <= 4'd1;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cnt_r <= cfg_data;
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.accept) begin
        j_r <= '0;
      end else if (cmd.mac_issue) begin
        j_r <= j_r + 1'b1;
      end
      if (cmd.accept) begin
        i_r <= 4'd1;
      end else if (cmd.eos_emit) begin
        i_r <= i_r + 4'd1;
      end
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r  <= in_data;
      base_r  <= AW'(int'(in_data.cell_index) * DELAYS);
      total_r <= 32'd0;
    end else if (cmd.eos_emit) begin
      total_r <= sat_add(total_r, sum_val);
    end
    wa1_r    <= rd_w_addr;
    last1_r  <= j_last;
    first1_r <= (j_r == '0);
    prod_r   <= 48'(item_r.sediment_yield) * 48'(rd_w_r);
    sh_r     <= last1_r ? 32'd0 : rd_d_r;
    wa2_r    <= wa1_r;
    first2_r <= first1_r;
    if (v2_r && first2_r) outflow_r <= mac_sum;
    if (cmd.err_emit) begin
      out_r.kind   <= KIND_ERROR;
      out_r.index  <= item_r.cell_index;
      out_r.amount <= 32'd0;
      out_r.last   <= 1'b1;
    end else if (cmd.sum_upd) begin
      out_r.kind   <= KIND_OUTFLOW;
      out_r.index  <= item_r.cell_index;
      out_r.amount <= outflow_r;
      out_r.last   <= 1'b1;
    end else if (cmd.eos_emit) begin
      out_r.kind   <= KIND_SUM;
      out_r.index  <= 10'(i_r);
      out_r.amount <= sum_val;
      out_r.last   <= 1'b0;
    end else if (cmd.total_emit) begin
      out_r.kind   <= KIND_TOTAL;
      out_r.index  <= 10'd0;
      out_r.amount <= total_r;
      out_r.last   <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hdl/unit_hydrograph_sediment_routing.sv @@
// Top level of the unit-hydrograph sediment routing block.
// Depends on uhsr_pkg, uhsr_ctrl, uhsr_datapath and the defines header.
`include "unit_hydrograph_sediment_routing_defines.svh"

// One word at a time. After reset a clearing pass zeroes every entry of the delay
// and weight memories with in_ready low (config writes still taken). A load word
// leaves the block ready for the next word. A cell-step word has the single 32x16
// multiply-accumulate unit make one pass per delay position, then waits for the
// pipe to drain, then reads and updates the subbasin sum.
// An end-of-step word is taken, then each subbasin sum is read and emitted in
// turn, then the total.
// The output register holds one result word; further results wait for out_ready.
module unit_hydrograph_sediment_routing import uhsr_pkg::*; #(
  parameter int CELLS     = 1024,
  parameter int DELAYS    = 16,
  parameter int SUBBASINS = 15
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  uhsr_in_word_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output uhsr_out_word_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [3:0]     cfg_data
);

  uhsr_cmd_t cmd;
  uhsr_sts_t sts;

  assign cfg_ready = 1'b1;

  uhsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uhsr_datapath #(
    .CELLS     (CELLS),
    .DELAYS    (DELAYS),
    .SUBBASINS (SUBBASINS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `UHSR_ASSERT_IMP(a_err_form, out_valid && out_data.kind == KIND_ERROR, out_data.amount == 32'd0 && out_data.last, "error word malformed")
  `UHSR_ASSERT_IMP(a_total_form, out_valid && out_data.kind == KIND_TOTAL, out_data.index == 10'd0 && out_data.last, "total word malformed")
  `UHSR_ASSERT_IMP(a_sum_not_last, out_valid && out_data.kind == KIND_SUM, !out_data.last, "subbasin sum marked last")
  `UHSR_ASSERT_NXT(a_step_busy, in_valid && in_ready && in_data.action == ACT_STEP, !in_ready, "ready after cell step")

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for unit_hydrograph_sediment_routing: queued words, random
// handshake idling, and an in-bench routing predictor checked field by field.
// Depends on uhsr_pkg and the block's RTL.
module testbench;
  import uhsr_pkg::*;

  localparam int CELL_COUNT  = 1024;
  localparam int SLOT_COUNT  = 16;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  uhsr_in_word_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  uhsr_out_word_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [3:0]     cfg_data = 4'd0;

  unit_hydrograph_sediment_routing dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // routing state mirrored by the bench
  bit [31:0] line_store [CELL_COUNT*SLOT_COUNT];
  bit [15:0] weight_rows [CELL_COUNT*SLOT_COUNT];
  bit [31:0] basin_sums [16];
  bit [3:0]  basin_count = 4'd1;

  uhsr_in_word_t  route_words_q [$];
  uhsr_out_word_t sediment_due_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          fail_count = 0;
  int          cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit [31:0] clip_add(input bit [31:0] a, input bit [31:0] b);
    bit [32:0] s;
    s = 33'(a) + 33'(b);
    return (s > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void push_due(input logic [1:0] kind, input logic [9:0] index,
                                   input logic [31:0] amount, input logic last);
    uhsr_out_word_t r;
    r.kind = kind;
    r.index = index;
    r.amount = amount;
    r.last = last;
    sediment_due_q.push_back(r);
  endfunction

  function automatic void route_sediment(input uhsr_in_word_t w);
    int        base;
    bit [47:0] prod;
    bit [31:0] outflow;
    bit [31:0] total;
    bit [3:0]  target;
    base = int'(w.cell_index) * SLOT_COUNT;
    case (w.action)
      ACT_LOAD: weight_rows[base + int'(w.delay_position)] = w.weight;
      ACT_STEP: begin
        for (int j = 0; j < SLOT_COUNT - 1; j++) line_store[base + j] = line_store[base + j + 1];
        line_store[base + SLOT_COUNT - 1] = '0;
        if (w.sediment_yield != 0) begin
          for (int j = 0; j < SLOT_COUNT; j++) begin
            prod = 48'(w.sediment_yield) * 48'(weight_rows[base + j]);
            line_store[base + j] = clip_add(line_store[base + j], prod[47:16]);
          end
        end
        outflow = line_store[base];
        target = (basin_count == 4'd1) ? 4'd1 : w.subbasin_id;
        if (target == 0 || target > basin_count) begin
          push_due(KIND_ERROR, w.cell_index, '0, 1'b1);
        end else begin
          basin_sums[target] = clip_add(basin_sums[target], outflow);
          push_due(KIND_OUTFLOW, w.cell_index, outflow, 1'b1);
        end
      end
      ACT_EOS: begin
        total = '0;
        for (int i = 1; i <= int'(basin_count); i++) begin
          push_due(KIND_SUM, 10'(i), basin_sums[i], 1'b0);
          total = clip_add(total, basin_sums[i]);
        end
        push_due(KIND_TOTAL, '0, total, 1'b1);
        for (int i = 0; i < 16; i++) basin_sums[i] = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic flag(input string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", what);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) route_sediment(in_data);
      if (!in_valid || in_ready) begin
        if (route_words_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= route_words_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    uhsr_out_word_t due;
    if (rst_n && out_valid && out_ready) begin
      if (sediment_due_q.size() == 0) begin
        flag($sformatf("unexpected word kind %0d index %0d amount %h last %0d",
                       out_data.kind, out_data.index, out_data.amount, out_data.last));
      end else begin
        due = sediment_due_q.pop_front();
        if (out_data.kind !== due.kind || out_data.index !== due.index ||
            out_data.amount !== due.amount || out_data.last !== due.last)
          flag($sformatf("exp kind %0d index %0d amount %h last %0d, got %0d %0d %h %0d",
                         due.kind, due.index, due.amount, due.last,
                         out_data.kind, out_data.index, out_data.amount, out_data.last));
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic uhsr_in_word_t make_word(input logic [1:0] action, input logic [9:0] cell_no,
                                              input logic [3:0] pos, input logic [15:0] weight,
                                              input logic [31:0] yield, input logic [3:0] sid);
    uhsr_in_word_t w;
    w.action = action;
    w.cell_index = cell_no;
    w.delay_position = pos;
    w.weight = weight;
    w.sediment_yield = yield;
    w.subbasin_id = sid;
    return w;
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (route_words_q.size() > 0 || in_valid || sediment_due_q.size() > 0);
  endtask

  task automatic write_subbasin_count(input logic [3:0] n);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_data <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    basin_count = n;
  endtask

  task automatic queue_random_words(input int n);
    uhsr_in_word_t w;
    int unsigned   r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      w.action = (r < 30) ? ACT_LOAD : (r < 80) ? ACT_STEP : (r < 93) ? ACT_EOS : ACT_NONE;
      w.cell_index = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(7));
      w.delay_position = 4'($urandom);
      w.weight = 16'($urandom);
      case ($urandom_range(9))
        0: w.sediment_yield = '0;
        1: w.sediment_yield = 32'hFFFF_FFFF;
        default: w.sediment_yield = $urandom;
      endcase
      if ($urandom_range(3) == 0 || basin_count == 0)
        w.subbasin_id = 4'($urandom);
      else
        w.subbasin_id = 4'($urandom_range(1, basin_count));
      route_words_q.push_back(w);
      if (k == n / 2) drain();
    end
  endtask

  initial begin
    send_idle_pct = 29;
    recv_idle_pct = 79;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // single subbasin: every id lands in subbasin 1
    write_subbasin_count(4'd1);
    route_words_q.push_back(make_word(ACT_LOAD, 10'd1023, 4'd0, 16'hFFFF, '0, '0));
    route_words_q.push_back(make_word(ACT_LOAD, 10'd1023, 4'd15, 16'hFFFF, '0, '0));
    route_words_q.push_back(make_word(ACT_LOAD, 10'd0, 4'd0, 16'h8000, '0, '0));
    route_words_q.push_back(make_word(ACT_LOAD, 10'd0, 4'd15, 16'h0001, '0, '0));
    route_words_q.push_back(make_word(ACT_STEP, 10'd1023, 4'd0, '0, 32'hFFFF_FFFF, 4'd0));
    route_words_q.push_back(make_word(ACT_STEP, 10'd1023, 4'd0, '0, 32'hFFFF_FFFF, 4'd9));
    route_words_q.push_back(make_word(ACT_STEP, 10'd0, 4'd0, '0, 32'd0, 4'd15));
    route_words_q.push_back(make_word(ACT_STEP, 10'd0, 4'd0, '0, 32'h0001_0000, 4'd1));
    route_words_q.push_back(make_word(ACT_NONE, 10'd5, 4'd3, 16'h1234, 32'h5, 4'd2));
    route_words_q.push_back(make_word(ACT_EOS, '0, '0, '0, '0, '0));

    write_subbasin_count(4'd15);
    route_words_q.push_back(make_word(ACT_STEP, 10'd1023, 4'd0, '0, 32'hFFFF_FFFF, 4'd15));
    route_words_q.push_back(make_word(ACT_STEP, 10'd0, 4'd0, '0, 32'hFFFF_FFFF, 4'd0));
    route_words_q.push_back(make_word(ACT_EOS, '0, '0, '0, '0, '0));

    // zero count: every id is bad, end of step gives the total alone
    write_subbasin_count(4'd0);
    route_words_q.push_back(make_word(ACT_STEP, 10'd0, 4'd0, '0, 32'd1, 4'd1));
    route_words_q.push_back(make_word(ACT_EOS, '0, '0, '0, '0, '0));

    // saturating sums and total, id above count
    write_subbasin_count(4'd2);
    route_words_q.push_back(make_word(ACT_STEP, 10'd1023, 4'd0, '0, 32'hFFFF_FFFF, 4'd1));
    route_words_q.push_back(make_word(ACT_STEP, 10'd1023, 4'd0, '0, 32'hFFFF_FFFF, 4'd1));
    route_words_q.push_back(make_word(ACT_STEP, 10'd1023, 4'd0, '0, 32'hFFFF_FFFF, 4'd2));
    route_words_q.push_back(make_word(ACT_STEP, 10'd0, 4'd0, '0, 32'h0003_0000, 4'd3));
    route_words_q.push_back(make_word(ACT_EOS, '0, '0, '0, '0, '0));
    route_words_q.push_back(make_word(ACT_LOAD, 10'd1023, 4'd7, 16'h0000, '0, '0));

    write_subbasin_count(4'd15);
    queue_random_words(27);

    send_idle_pct = 79;
    recv_idle_pct = 29;
    write_subbasin_count(4'd3);
    queue_random_words(27);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_subbasin_count(4'($urandom_range(15)));
    queue_random_words(27);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
